// File: sv/binary_mask_erode_3x3_defines.svh
// assertion macros for the erosion block checker
`ifndef BINARY_MASK_ERODE_3X3_DEFINES_SVH
`define BINARY_MASK_ERODE_3X3_DEFINES_SVH

// a stalled result keeps its valid and its payload
`define BME3_STALL_HOLD(label, vld, rdy, data) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(data))) \
        else $error("stalled result changed");

// plain implication checked at every edge
`define BME3_IMPLY(label, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (lhs) |-> (rhs)) \
        else $error("implication failed");

`endif

// File: sv/bme3_pkg.sv
package bme3_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_INDEX_W    = 8;
    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 8'd0,
        REG_IMAGE_HEIGHT = 8'd1
    } cfg_reg_t;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    // per-item control carried from the accept stage to the window stage
    typedef struct packed {
        logic have;
        logic last;
        logic draining;
        logic col0;
        logic lok;
        logic rok;
        logic tok;
        logic bok;
        logic bit_in;
    } stage_ctl_t;

    // each group: bit0 row above, bit1 centre row, bit2 row below
    function automatic logic erode_window(
        input logic [2:0] gl,
        input logic [2:0] gc,
        input logic [2:0] gr,
        input logic       lok,
        input logic       rok,
        input logic       tok,
        input logic       bok
    );
        logic [2:0] need;
        need = {bok, 1'b1, tok};
        return ((gc & need) == need)
            && (!lok || ((gl & need) == need))
            && (!rok || ((gr & need) == need));
    endfunction

endpackage

// File: sv/bme3_pixel_if.sv
interface bme3_pixel_if;
    logic valid;
    logic ready;
    logic operation;
    logic mask_bit;

    modport source (output valid, output operation, output mask_bit, input ready);
    modport sink (input valid, input operation, input mask_bit, output ready);
endinterface

// File: sv/bme3_result_if.sv
interface bme3_result_if;
    logic valid;
    logic ready;
    logic eroded_bit;
    logic frame_end;

    modport source (output valid, output eroded_bit, output frame_end, input ready);
    modport sink (input valid, input eroded_bit, input frame_end, output ready);
endinterface

// File: sv/bme3_cfg_if.sv
interface bme3_cfg_if
    import bme3_pkg::*;
;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/binary_mask_erode_3x3.sv
// channel   dir  payload                     transaction when
// pixel     in   operation, mask_bit         pixel.valid && pixel.ready
// result    out  eroded_bit, frame_end       result.valid && result.ready
// cfg       in   index, data                 cfg.valid (ready always high)
//
// one item per clock sustained while the sink takes results; a result is loaded
// into the output register when its item leaves stage 1 (line buffer read at
// accept, then window and erode), and is held there until the sink takes it
// both line buffers share one 2-bit memory, read at accept, written when the
// item leaves stage 1 unless draining; a same-address write is bypassed to the
// read register; reset clears counters, window and valids only; no clearing pass
// a stalled result holds in its register while one more item waits in stage 1
module binary_mask_erode_3x3
    import bme3_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    bme3_pixel_if.sink      pixel,
    bme3_result_if.source   result,
    bme3_cfg_if.sink        cfg
);

    localparam int DW   = $clog2(MAX_WIDTH + 1);
    localparam int CLW  = $clog2(MAX_WIDTH);
    localparam int XW   = CLW + 1;
    localparam int HW   = $clog2(MAX_HEIGHT + 1);
    localparam int RW   = $clog2(MAX_HEIGHT + 2);
    localparam int CWW  = (DW > CFG_DATA_W) ? DW : CFG_DATA_W;
    localparam int CHW  = (HW > CFG_DATA_W) ? HW : CFG_DATA_W;
    localparam int WIDTH_RST  = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int HEIGHT_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    logic [DW-1:0]  width_reg, width_next;
    logic [HW-1:0]  height_reg, height_next;
    logic [CLW-1:0] col_reg, col_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [8:0]     window_reg, window_next;

    logic           s1_valid_reg, s1_valid_next;
    stage_ctl_t     s1_ctl_reg;
    logic [CLW-1:0] s1_col_reg;
    logic [1:0]     rd_data_reg;

    logic           res_valid_reg, res_valid_next;
    logic           eroded_reg;
    logic           frame_end_reg;

    logic [1:0]     line_mem [MAX_WIDTH];

    logic           cfg_wr;
    logic           cfg_hit;
    logic [CWW-1:0] cfg_w_ext;
    logic [CHW-1:0] cfg_h_ext;
    logic           accept;
    logic           take;
    logic           draining;
    logic           col0;
    logic           wrap;
    logic [XW-1:0]  col_inc;
    logic [RW-1:0]  h_ext;
    stage_ctl_t     ctl;
    logic           s1_move;
    logic           wr_en;
    logic [1:0]     wr_data;
    logic           fwd;
    logic [2:0]     col_bits;
    logic [8:0]     shifted;
    logic           res_bit;

    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;
    // only a write to a known register restarts the frame
    assign cfg_hit   = cfg_wr && ((cfg.index == REG_IMAGE_WIDTH)
                                  || (cfg.index == REG_IMAGE_HEIGHT));
    assign cfg_w_ext = CWW'(cfg.data);
    assign cfg_h_ext = CHW'(cfg.data);

    // register writes clamp to 1..max and restart the frame
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr && (cfg.index == REG_IMAGE_WIDTH))
        begin
            if (cfg_w_ext == '0)
                width_next = DW'(1);
            else if (cfg_w_ext > CWW'(MAX_WIDTH))
                width_next = DW'(MAX_WIDTH);
            else
                width_next = DW'(cfg_w_ext);
        end
        if (cfg_wr && (cfg.index == REG_IMAGE_HEIGHT))
        begin
            if (cfg_h_ext == '0)
                height_next = HW'(1);
            else if (cfg_h_ext > CHW'(MAX_HEIGHT))
                height_next = HW'(MAX_HEIGHT);
            else
                height_next = HW'(cfg_h_ext);
        end
    end

    // accept stage: raster position and window geometry
    assign h_ext    = RW'(height_reg);
    assign draining = (row_reg >= h_ext);
    assign col0     = (col_reg == '0);
    assign col_inc  = XW'(col_reg) + XW'(1);
    assign wrap     = (col_inc >= XW'(width_reg));
    assign accept   = pixel.valid && pixel.ready;
    // drain ticks before the frame is in are dropped
    assign take     = accept && !((pixel.operation == OP_DRAIN) && !draining);

    always_comb
    begin
        ctl.draining = draining;
        ctl.col0     = col0;
        ctl.bit_in   = pixel.mask_bit;
        if (col0)
        begin
            // closes the last column of the row two back
            ctl.have = (row_reg >= RW'(2));
            ctl.last = (row_reg == (h_ext + RW'(1)));
            ctl.lok  = (width_reg >= DW'(2));
            ctl.rok  = 1'b0;
            ctl.tok  = (row_reg >= RW'(3));
            ctl.bok  = (row_reg <= h_ext);
        end
        else
        begin
            ctl.have = (row_reg != '0);
            ctl.last = 1'b0;
            ctl.lok  = (col_reg >= CLW'(2));
            ctl.rok  = 1'b1;
            ctl.tok  = (row_reg >= RW'(2));
            ctl.bok  = !draining;
        end
    end

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (take)
        begin
            if (ctl.last)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (wrap)
            begin
                col_next = '0;
                row_next = row_reg + RW'(1);
            end
            else
            begin
                col_next = CLW'(col_inc);
            end
        end
    end

    // window stage
    assign s1_move = s1_valid_reg && (!s1_ctl_reg.have || !res_valid_reg || result.ready);
    assign pixel.ready = !s1_valid_reg || s1_move;

    assign s1_valid_next = take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);

    // entry bit0 = row two above, bit1 = row above
    assign wr_en   = s1_move && !s1_ctl_reg.draining;
    assign wr_data = {s1_ctl_reg.bit_in, rd_data_reg[1]};
    assign fwd     = wr_en && (s1_col_reg == col_reg);

    assign col_bits = {(s1_ctl_reg.draining ? 1'b0 : s1_ctl_reg.bit_in),
                       rd_data_reg[1], rd_data_reg[0]};
    assign shifted  = {col_bits, window_reg[8:3]};

    always_comb
    begin
        if (s1_ctl_reg.col0)
            res_bit = erode_window(window_reg[5:3], window_reg[8:6], 3'b000,
                                   s1_ctl_reg.lok, 1'b0, s1_ctl_reg.tok, s1_ctl_reg.bok);
        else
            res_bit = erode_window(shifted[2:0], shifted[5:3], shifted[8:6],
                                   s1_ctl_reg.lok, s1_ctl_reg.rok, s1_ctl_reg.tok,
                                   s1_ctl_reg.bok);
    end

    always_comb
    begin
        window_next = window_reg;
        if (cfg_hit)
            window_next = '0;
        else if (s1_move)
            window_next = s1_ctl_reg.last ? 9'd0 : shifted;
    end

    always_comb
    begin
        if (s1_move && s1_ctl_reg.have)
            res_valid_next = 1'b1;
        else if (result.ready)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= DW'(WIDTH_RST);
            height_reg    <= HW'(HEIGHT_RST);
            col_reg       <= '0;
            row_reg       <= '0;
            window_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            width_reg     <= width_next;
            height_reg    <= height_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            window_reg    <= window_next;
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_ctl_reg <= ctl;
            s1_col_reg <= col_reg;
        end
        if (s1_move && s1_ctl_reg.have)
        begin
            eroded_reg    <= res_bit;
            frame_end_reg <= s1_ctl_reg.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_mem[s1_col_reg] <= wr_data;
        if (take)
            rd_data_reg <= fwd ? wr_data : line_mem[col_reg];
    end

    assign result.valid      = res_valid_reg;
    assign result.eroded_bit = eroded_reg;
    assign result.frame_end  = frame_end_reg;

endmodule

// File: sv/bme3_checker.sv
`include "binary_mask_erode_3x3_defines.svh"

module bme3_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_eroded,
    input logic out_frame_end
);

    `BME3_STALL_HOLD(a_result_hold, out_valid, out_ready, {out_eroded, out_frame_end})
    // with the result register empty the window stage always drains
    `BME3_IMPLY(a_ready_when_empty, !out_valid, in_ready)
    // a fresh result comes from an item taken into stage 1 and then loaded into the result register
    `BME3_IMPLY(a_result_source, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind binary_mask_erode_3x3 bme3_checker u_bme3_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pixel.valid),
    .in_ready      (pixel.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_eroded    (result.eroded_bit),
    .out_frame_end (result.frame_end)
);

// File: tb/testbench.sv
module testbench;
    import bme3_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 1000000;
    localparam int unsigned RANDOM_ITEMS = 1050;
    localparam int unsigned SETTLE       = 6;

    typedef struct packed {
        logic eroded_bit;
        logic frame_end;
    } erosion_result_t;

    typedef enum int {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_BURSTY
    } rx_pattern_t;

    // predicts the eroded stream and checks what the block returns
    class erosion_scoreboard;
        bit              line_above[MAX_WIDTH_DEF];
        bit              line_two_above[MAX_WIDTH_DEF];
        bit [8:0]        window;
        int unsigned     in_col;
        int unsigned     in_row;
        logic [10:0]     width_reg;
        logic [10:0]     height_reg;
        erosion_result_t expected_q[$];
        int unsigned     errors;
        int unsigned     inputs_taken;
        int unsigned     results_checked;
        int unsigned     frames_done;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            restart();
        endfunction

        function void restart();
            window = '0;
            in_col = 0;
            in_row = 0;
        endfunction

        function int unsigned clamp_dim(logic [10:0] v, int unsigned maxv);
            if (v == 0)
                return 1;
            if (v > maxv)
                return maxv;
            return v;
        endfunction

        function int unsigned cur_width();
            return clamp_dim(width_reg, MAX_WIDTH_DEF);
        endfunction

        function int unsigned cur_height();
            return clamp_dim(height_reg, MAX_HEIGHT_DEF);
        endfunction

        function void set_reg(cfg_reg_t idx, logic [10:0] v);
            case (idx)
                REG_IMAGE_WIDTH:  width_reg = v;
                REG_IMAGE_HEIGHT: height_reg = v;
                default: return;
            endcase
            restart();
        endfunction

        // bit0 row above, bit1 centre, bit2 row below
        function bit survives(bit [2:0] gl, bit [2:0] gc, bit [2:0] gr,
                              bit lok, bit rok, bit tok, bit bok);
            bit [2:0] need;
            need = {bok, 1'b1, tok};
            if ((gc & need) != need)
                return 0;
            if (lok && ((gl & need) != need))
                return 0;
            if (rok && ((gr & need) != need))
                return 0;
            return 1;
        endfunction

        // returns 0 when the block ignores the transaction
        function bit note_item(op_t op, bit m);
            int unsigned     w;
            int unsigned     h;
            int unsigned     c;
            int unsigned     r;
            int unsigned     orow;
            int unsigned     ocol;
            bit              draining;
            bit              have;
            bit              last;
            bit              res;
            bit [2:0]        col;
            erosion_result_t exp_res;
            w = cur_width();
            h = cur_height();
            draining = (in_row >= h);
            have = 0;
            last = 0;
            res = 0;
            orow = 0;
            ocol = 0;
            if (op == OP_DRAIN && !draining)
                return 0;
            inputs_taken++;
            c = in_col;
            r = in_row;
            if (c >= w)
                c = 0;
            col = {draining ? 1'b0 : m, line_above[c], line_two_above[c]};
            if (!draining)
            begin
                line_two_above[c] = line_above[c];
                line_above[c] = m;
            end
            if (c == 0)
            begin
                if (r >= 2)
                begin
                    orow = r - 2;
                    ocol = w - 1;
                    res = survives(window[5:3], window[8:6], 3'b000,
                                   ocol >= 1, 1'b0, orow >= 1, orow + 1 < h);
                    have = 1;
                end
                window = {col, window[8:3]};
            end
            else
            begin
                window = {col, window[8:3]};
                if (r >= 1)
                begin
                    orow = r - 1;
                    ocol = c - 1;
                    res = survives(window[2:0], window[5:3], window[8:6],
                                   ocol >= 1, ocol + 1 < w, orow >= 1, orow + 1 < h);
                    have = 1;
                end
            end
            if (have)
                last = (orow + 1 == h) && (ocol + 1 == w);
            if (last)
                restart();
            else
            begin
                c++;
                if (c >= w)
                begin
                    c = 0;
                    r++;
                end
                in_col = c;
                in_row = r;
            end
            if (have)
            begin
                exp_res.eroded_bit = res;
                exp_res.frame_end  = last;
                expected_q.push_back(exp_res);
            end
            return 1;
        endfunction

        function void check_result(logic eroded, logic fend);
            erosion_result_t exp_res;
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual eroded_bit %b frame_end %b",
                         $time, eroded, fend);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            results_checked++;
            if (exp_res.frame_end)
                frames_done++;
            if (eroded !== exp_res.eroded_bit)
            begin
                $display("%0t: eroded_bit mismatch, expected %b, actual %b",
                         $time, exp_res.eroded_bit, eroded);
                errors++;
            end
            if (fend !== exp_res.frame_end)
            begin
                $display("%0t: frame_end mismatch, expected %b, actual %b",
                         $time, exp_res.frame_end, fend);
                errors++;
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    bme3_pixel_if  pixel_ch();
    bme3_result_if result_ch();
    bme3_cfg_if    cfg_ch();

    binary_mask_erode_3x3 dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .pixel  (pixel_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    erosion_scoreboard board = new();

    int unsigned cycle_count = 0;
    int unsigned reg_writes  = 0;
    int unsigned burst_left  = 0;
    int unsigned gap_max     = 0;
    rx_pattern_t rx_pattern  = RX_ALWAYS;
    int unsigned rx_tick     = 0;
    int unsigned hold_left   = 0;
    bit          hold_level  = 1'b1;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        pixel_ch.valid = 1'b0;
        pixel_ch.operation = OP_PIXEL;
        pixel_ch.mask_bit = 1'b0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_IMAGE_WIDTH;
        cfg_ch.data = '0;
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        rx_tick++;
        case (rx_pattern)
            RX_ALWAYS:   result_ch.ready <= 1'b1;
            RX_RANDOM:   result_ch.ready <= ($urandom_range(0, 99) < 70);
            RX_PERIODIC: result_ch.ready <= ((rx_tick % 9) >= 3);
            default:
            begin
                if (hold_left == 0)
                begin
                    hold_level = $urandom_range(0, 1);
                    hold_left  = $urandom_range(1, 12);
                end
                hold_left--;
                result_ch.ready <= hold_level;
            end
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
            board.check_result(result_ch.eroded_bit, result_ch.frame_end);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, board.pending());
            $display("** binary_mask_erode_3x3: FAILED **");
            $finish;
        end
    end

    task automatic send_item(input op_t op, input bit m, output bit taken);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                pixel_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        pixel_ch.valid <= 1'b1;
        pixel_ch.operation <= op;
        pixel_ch.mask_bit <= m;
        do
            @(posedge clk);
        while (!pixel_ch.ready);
        taken = board.note_item(op, m);
    endtask

    // let the pipeline empty before touching registers or finishing
    task automatic wait_idle(input int unsigned extra);
        pixel_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [10:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= v;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        board.set_reg(idx, v);
        reg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(input logic [10:0] wv, input logic [10:0] hv);
        wait_idle(SETTLE);
        write_reg(REG_IMAGE_WIDTH, wv);
        write_reg(REG_IMAGE_HEIGHT, hv);
    endtask

    // a frame of pixels then the flush, or a cut-off frame alone; noise
    // mixes in stray drain ticks and pixel transactions during the flush
    task automatic run_frame(input int unsigned noise, input bit truncate,
                             output int unsigned consumed);
        int unsigned w;
        int unsigned npix;
        int unsigned stop;
        int unsigned density;
        bit          taken;
        w = board.cur_width();
        npix = w * board.cur_height();
        stop = (truncate && npix > 1) ? $urandom_range(1, npix - 1) : npix;
        consumed = 0;
        case ($urandom_range(0, 3))
            0: density = 50;
            1: density = 85;
            2: density = 97;
            default: density = 100;
        endcase
        for (int unsigned i = 0; i < stop; i++)
        begin
            if ($urandom_range(0, 99) < noise)
                send_item(OP_DRAIN, $urandom_range(0, 1), taken);
            send_item(OP_PIXEL, $urandom_range(0, 99) < density, taken);
            consumed++;
        end
        if (!(truncate && npix > 1))
        begin
            for (int unsigned j = 0; j <= w; j++)
            begin
                send_item(($urandom_range(0, 99) < noise) ? OP_PIXEL : OP_DRAIN,
                          $urandom_range(0, 1), taken);
                consumed++;
            end
            // after the frame end a drain tick is ignored again
            if ($urandom_range(0, 99) < noise)
                send_item(OP_DRAIN, $urandom_range(0, 1), taken);
        end
    endtask

    initial
    begin
        bit          taken;
        int unsigned consumed;
        int unsigned random_items;
        int unsigned frames;
        logic [10:0] wv;
        logic [10:0] hv;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero sizes act as a single pixel frame
        gap_max = 0;
        rx_pattern = RX_ALWAYS;
        set_size(11'd0, 11'd0);
        send_item(OP_DRAIN, 1'b1, taken);
        send_item(OP_PIXEL, 1'b1, taken);
        send_item(OP_DRAIN, 1'b0, taken);
        send_item(OP_DRAIN, 1'b1, taken);
        send_item(OP_DRAIN, 1'b0, taken);
        send_item(OP_PIXEL, 1'b0, taken);
        send_item(OP_DRAIN, 1'b0, taken);
        send_item(OP_PIXEL, 1'b1, taken);

        // 3x2 frame with one hole, pixel transaction inside the flush
        rx_pattern = RX_PERIODIC;
        set_size(11'd3, 11'd2);
        send_item(OP_PIXEL, 1'b1, taken);
        send_item(OP_PIXEL, 1'b1, taken);
        send_item(OP_PIXEL, 1'b1, taken);
        send_item(OP_PIXEL, 1'b1, taken);
        send_item(OP_PIXEL, 1'b0, taken);
        send_item(OP_PIXEL, 1'b1, taken);
        send_item(OP_PIXEL, 1'b1, taken);
        send_item(OP_DRAIN, 1'b0, taken);
        send_item(OP_DRAIN, 1'b1, taken);
        send_item(OP_DRAIN, 1'b0, taken);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0:       wv = 11'd0;
                1, 2, 3,
                4, 5, 6: wv = $urandom_range(1, 8);
                7, 8:    wv = $urandom_range(9, 32);
                default: wv = $urandom_range(33, 80);
            endcase
            case ($urandom_range(0, 11))
                0:       hv = 11'd0;
                1:       hv = (wv > 32) ? $urandom_range(1, 3) : $urandom_range(7, 12);
                default: hv = (wv > 32) ? $urandom_range(1, 3) : $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 3))
                0:       gap_max = 0;
                1, 2:    gap_max = 3;
                default: gap_max = 10;
            endcase
            rx_pattern = rx_pattern_t'($urandom_range(0, 3));
            wait_idle(SETTLE);
            case ($urandom_range(0, 3))
                0:       write_reg(REG_IMAGE_WIDTH, wv);
                1:       write_reg(REG_IMAGE_HEIGHT, hv);
                default:
                begin
                    write_reg(REG_IMAGE_WIDTH, wv);
                    write_reg(REG_IMAGE_HEIGHT, hv);
                end
            endcase
            frames = $urandom_range(1, 3);
            for (int unsigned f = 0; f < frames && random_items < RANDOM_ITEMS; f++)
            begin
                // a cut-off frame ends the setting, the next write restarts it
                if ($urandom_range(0, 9) == 0)
                begin
                    run_frame($urandom_range(0, 15), 1'b1, consumed);
                    random_items += consumed;
                    break;
                end
                run_frame($urandom_range(0, 15), 1'b0, consumed);
                random_items += consumed;
            end
        end

        wait_idle(10);
        $display("covered %0d input transactions, %0d results, %0d frame ends,",
                 board.inputs_taken, board.results_checked, board.frames_done);
        $display("%0d register writes, sizes from one pixel up to 80 wide and 12 tall",
                 reg_writes);
        if (board.errors == 0 && board.pending() == 0)
            $display("** binary_mask_erode_3x3: PASSED **");
        else
            $display("** binary_mask_erode_3x3: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/bme3_pkg.sv
sv/bme3_pixel_if.sv
sv/bme3_result_if.sv
sv/bme3_cfg_if.sv
sv/binary_mask_erode_3x3.sv
sv/bme3_checker.sv
tb/testbench.sv
